// ----- rtl/set_assoc_cache_tag_store_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag store
// Shared property wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH

// checked outside reset only
`define SCTAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define SCTAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/sctag_pkg.sv -----
// ----------------------------------------------------------------------------
// sctag_pkg
// Types, codes and helpers shared by the cache tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sctag_pkg;

  localparam int ADDR_W     = 64;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int SHIFT_W    = 5;
  localparam int VCTR_W     = 32;

  localparam logic [CMD_W-1:0] CMD_PREFETCH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITEBACK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FETCH     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SHIFT = 1'b1;

  typedef struct packed {
    logic writes;   // write or writeback: line ends dirty
    logic counts;   // miss is counted
  } sctag_kind_t;

  typedef struct packed {
    logic clearing; // reset sweep of the set memory in progress
  } sctag_status_t;

  typedef struct packed {
    logic              hit;
    logic              counted_miss;
    logic              evict_dirty;
    logic [ADDR_W-1:0] evict_address;
  } sctag_result_t;

  function automatic int flog2(input int n);
    int c;
    int v;
    c = 0;
    v = n;
    while (v > 1) begin
      v = v / 2;
      c = c + 1;
    end
    return c;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/set_assoc_cache_tag_store.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Tag store of a set-associative write-back cache with LRU or counter
// replacement and dirty-victim reporting.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  access  | in_valid_i/in_ready_o, cmd_i, address_i      | in
//  result  | out_valid_o/out_ready_i, hit_o, counted_miss_o,| out
//          | evict_dirty_o, evict_address_o               |
//  config  | cfg_we_i, cfg_index_i, cfg_data_i            | in
//
//  Each transaction passes the back end in order: a read of the set row
//  from the set memory, then an evaluation that writes the row back and
//  loads the result register. The back takes no new transaction until
//  the last is through, bound by the set memory's single read/write port.
//  After reset a clearing pass over every set initializes valid, dirty and
//  recency rows; in_ready_o is low during it (config writes still taken).
//  A 2-entry queue between front and back absorbs input stalls; the back
//  only starts a transaction when the result register is free or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_store #(
  parameter int SETS       = 1024,
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [sctag_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [sctag_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [sctag_pkg::CMD_W-1:0]           cmd_i,
  input  wire  [sctag_pkg::ADDR_W-1:0]          address_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic                                  hit_o,
  output logic                                  counted_miss_o,
  output logic                                  evict_dirty_o,
  output logic [sctag_pkg::ADDR_W-1:0]          evict_address_o
);
  import sctag_pkg::*;

  localparam int OFF_BITS = flog2(LINE_BYTES);
  localparam int IDX_BITS = flog2(SETS);
  localparam int SET_W    = imax(1, $clog2(SETS));
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int ENT_W    = 2 + SET_W + TAG_W;   // kind, set, tag

  logic               policy_q;
  logic [SHIFT_W-1:0] index_shift_q;

  sctag_status_t      status;
  sctag_result_t      result;
  logic               push_valid, push_ready, q_valid, q_ready;
  logic [ENT_W-1:0]   push_data, q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= 1'b0;
      index_shift_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POLICY:      policy_q      <= cfg_data_i[0];
        CFG_INDEX_SHIFT: index_shift_q <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: split address, classify command
  sctag_front #(
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES),
    .ENT_W      (ENT_W)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .address_i     (address_i),
    .index_shift_i (index_shift_q),
    .status_i      (status),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // decoupling queue
  sctag_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // back: set memory read-modify-write and result
  sctag_back #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_i    (policy_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign hit_o           = result.hit;
  assign counted_miss_o  = result.counted_miss;
  assign evict_dirty_o   = result.evict_dirty;
  assign evict_address_o = result.evict_address;

endmodule

`default_nettype wire

// ----- rtl/sctag_front.sv -----
// ----------------------------------------------------------------------------
// sctag_front
// Splits an access into set and tag and classifies its command.
// ----------------------------------------------------------------------------
`default_nettype none

module sctag_front #(
  parameter int SETS       = 1024,
  parameter int LINE_BYTES = 64,
  parameter int ENT_W      = 60
) (
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [sctag_pkg::CMD_W-1:0]         cmd_i,
  input  wire  [sctag_pkg::ADDR_W-1:0]        address_i,
  input  wire  [sctag_pkg::SHIFT_W-1:0]       index_shift_i,
  input  sctag_pkg::sctag_status_t            status_i,
  output logic                                push_valid_o,
  input  wire                                 push_ready_i,
  output logic [ENT_W-1:0]                    push_data_o
);
  import sctag_pkg::*;

  localparam int OFF_BITS = flog2(LINE_BYTES);
  localparam int IDX_BITS = flog2(SETS);
  localparam int SET_W    = imax(1, $clog2(SETS));
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;

  logic [ADDR_W-1:0] line_addr;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;
  sctag_kind_t       kind;

  assign line_addr = address_i >> OFF_BITS;
  assign shifted   = line_addr >> index_shift_i;
  assign set_idx   = SET_W'(shifted & ADDR_W'(SETS - 1));
  assign tag       = TAG_W'(line_addr >> IDX_BITS);

  // unknown codes behave as a data read
  assign kind.writes = (cmd_i == CMD_WRITE) || (cmd_i == CMD_WRITEBACK);
  assign kind.counts = !((cmd_i == CMD_WRITEBACK) || (cmd_i == CMD_PREFETCH));

  assign push_valid_o = in_valid_i && !status_i.clearing;
  assign in_ready_o   = push_ready_i && !status_i.clearing;
  assign push_data_o  = {kind, set_idx, tag};

endmodule

`default_nettype wire

// ----- rtl/sctag_fifo.sv -----
// ----------------------------------------------------------------------------
// sctag_fifo
// Small queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sctag_fifo #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  wire  [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  wire              pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sctag_back.sv -----
// ----------------------------------------------------------------------------
// sctag_back
// Set memory, lookup, replacement and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_cache_tag_store_assert.svh"

module sctag_back #(
  parameter int SETS       = 1024,
  parameter int WAYS       = 16,
  parameter int LINE_BYTES = 64,
  parameter int ENT_W      = 60
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         policy_i,
  input  wire                         q_valid_i,
  output logic                        q_ready_o,
  input  wire  [ENT_W-1:0]            q_data_i,
  output sctag_pkg::sctag_status_t    status_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output sctag_pkg::sctag_result_t    result_o
);
  import sctag_pkg::*;

  localparam int OFF_BITS = flog2(LINE_BYTES);
  localparam int IDX_BITS = flog2(SETS);
  localparam int SET_W    = imax(1, $clog2(SETS));
  localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int WAY_W    = imax(1, $clog2(WAYS));

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [SET_W-1:0]        clr_cnt_q, clr_cnt_d;
  logic [VCTR_W-1:0]       vctr_q, vctr_d;
  logic [WAY_W-1:0]        vmod_q, vmod_d;
  logic                    out_valid_q, out_valid_d;
  sctag_result_t           res_q;

  // set memory, one row per set
  logic [WAYS*TAG_W-1:0]   mem_tag [SETS];
  logic [WAYS-1:0]         mem_vld [SETS];
  logic [WAYS-1:0]         mem_drt [SETS];
  logic [WAYS*WAY_W-1:0]   mem_ord [SETS];

  logic [WAYS*TAG_W-1:0]   rd_tag_q;
  logic [WAYS-1:0]         rd_vld_q, rd_drt_q;
  logic [WAYS*WAY_W-1:0]   rd_ord_q;
  logic [ENT_W-1:0]        ent_q;

  sctag_kind_t             ent_kind;
  logic [SET_W-1:0]        ent_set, q_set;
  logic [TAG_W-1:0]        ent_tag;

  logic                    pop, eval, we;
  logic [SET_W-1:0]        waddr;
  logic [WAYS-1:0]         hit_vec, seen;
  logic                    hit, found_inv, adv, ev_dirty;
  logic [WAY_W-1:0]        hit_way, hit_pos, inv_pos, vic_pos, mv_pos, vic_way;
  logic [WAY_W-1:0]        ord [WAYS];
  logic [WAYS*TAG_W-1:0]   new_tag, wr_tag;
  logic [WAYS-1:0]         new_vld, new_drt, wr_vld, wr_drt;
  logic [WAYS*WAY_W-1:0]   new_ord, wr_ord, ord_init;
  logic [TAG_W-1:0]        vic_tag;
  logic [ADDR_W-1:0]       ev_addr;

  assign {ent_kind, ent_set, ent_tag} = ent_q;
  assign q_set = q_data_i[TAG_W +: SET_W];

  assign pop       = (state_q == ST_IDLE) && q_valid_i && (!out_valid_q || out_ready_i);
  assign eval      = (state_q == ST_EVAL);
  assign q_ready_o = pop;
  assign status_o.clearing = (state_q == ST_CLEAR);

  // lookup and replacement on the registered set row
  always_comb begin
    hit_vec   = '0;
    hit_way   = '0;
    hit_pos   = '0;
    inv_pos   = '0;
    found_inv = 1'b0;
    seen      = '0;
    for (int p = 0; p < WAYS; p++) begin
      ord[p] = rd_ord_q[p*WAY_W +: WAY_W];
      seen[ord[p]] = 1'b1;
    end
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rd_vld_q[w] && (rd_tag_q[w*TAG_W +: TAG_W] == ent_tag);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    hit = |hit_vec;
    for (int p = 0; p < WAYS; p++) begin
      if (ord[p] == hit_way) begin
        hit_pos = WAY_W'(p);
      end
    end
    // first invalid way in recency order
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (!rd_vld_q[ord[p]]) begin
        inv_pos   = WAY_W'(p);
        found_inv = 1'b1;
      end
    end
    if (found_inv) begin
      vic_pos = inv_pos;
    end else if (policy_i) begin
      vic_pos = vmod_q;
    end else begin
      vic_pos = WAY_W'(WAYS - 1);
    end
    vic_way = ord[vic_pos];
    mv_pos  = hit ? hit_pos : vic_pos;
    adv     = !hit && !found_inv && policy_i;

    new_ord = rd_ord_q;
    if (!policy_i) begin
      new_ord[0 +: WAY_W] = ord[mv_pos];
      for (int p = 1; p < WAYS; p++) begin
        if (WAY_W'(p) <= mv_pos) begin
          new_ord[p*WAY_W +: WAY_W] = ord[p-1];
        end
      end
    end

    new_tag = rd_tag_q;
    new_vld = rd_vld_q;
    new_drt = rd_drt_q;
    vic_tag = rd_tag_q[vic_way*TAG_W +: TAG_W];
    if (hit) begin
      new_drt[hit_way] = rd_drt_q[hit_way] | ent_kind.writes;
    end else begin
      new_tag[vic_way*TAG_W +: TAG_W] = ent_tag;
      new_vld[vic_way] = 1'b1;
      new_drt[vic_way] = ent_kind.writes;
    end

    ev_dirty = !hit && rd_vld_q[vic_way] && rd_drt_q[vic_way];
    ev_addr  = '0;
    if (ev_dirty) begin
      ev_addr = ((ADDR_W'(vic_tag) << IDX_BITS) + ADDR_W'(ent_set)) << OFF_BITS;
    end

    for (int p = 0; p < WAYS; p++) begin
      ord_init[p*WAY_W +: WAY_W] = WAY_W'(p);
    end
  end

  // memory write: reset sweep or update of the evaluated set
  always_comb begin
    we     = status_o.clearing || eval;
    waddr  = status_o.clearing ? clr_cnt_q : ent_set;
    wr_tag = status_o.clearing ? '0 : new_tag;
    wr_vld = status_o.clearing ? '0 : new_vld;
    wr_drt = status_o.clearing ? '0 : new_drt;
    wr_ord = status_o.clearing ? ord_init : new_ord;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_tag[waddr] <= wr_tag;
      mem_vld[waddr] <= wr_vld;
      mem_drt[waddr] <= wr_drt;
      mem_ord[waddr] <= wr_ord;
    end
    if (pop) begin
      rd_tag_q <= mem_tag[q_set];
      rd_vld_q <= mem_vld[q_set];
      rd_drt_q <= mem_drt[q_set];
      rd_ord_q <= mem_ord[q_set];
      ent_q    <= q_data_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    vctr_d      = vctr_q;
    vmod_d      = vmod_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SET_W'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (adv) begin
          vctr_d = vctr_q + 1'b1;
          // keep vmod equal to vctr mod WAYS, including the 2^32 wrap
          if (vctr_q == '1 || vmod_q == WAY_W'(WAYS - 1)) begin
            vmod_d = '0;
          end else begin
            vmod_d = vmod_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      vctr_q      <= '0;
      vmod_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      vctr_q      <= vctr_d;
      vmod_q      <= vmod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval) begin
      res_q.hit           <= hit;
      res_q.counted_miss  <= !hit && ent_kind.counts;
      res_q.evict_dirty   <= ev_dirty;
      res_q.evict_address <= ev_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `SCTAG_ASSERT_ALWAYS(a_hit_unique, (state_q == ST_EVAL) |-> $onehot0(hit_vec), "tag in two ways")
  `SCTAG_ASSERT(a_ord_perm, (state_q == ST_EVAL) |-> ($countones(seen) == WAYS), "recency not a permutation")
  `SCTAG_ASSERT(a_out_free, (state_q == ST_EVAL) |-> !out_valid_q, "result register overrun")
  `SCTAG_ASSERT(a_pop_eval, pop |=> (state_q == ST_EVAL), "popped entry not evaluated")

endmodule

`default_nettype wire
